// ===== rtl/gnos_pkg.sv =====
// ----------------------------------------------------------------------------
// gnos_pkg: shared types and constants for the gradient noise octave sum
// Fixed-point formats, input mode codes, register indexes, divider words and
// the gradient selection function.
// ----------------------------------------------------------------------------
package gnos_pkg;

  // Fixed-point and datapath widths.
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_AW    = 8;
  localparam int MAX_OCTAVES = 8;
  localparam int CW          = FRAC_BITS + TABLE_AW;  // kept coordinate bits
  localparam int DW          = 24;                    // signed datapath word
  localparam int PW          = 2 * DW;                // product word
  localparam int TW          = 44;                    // weighted sum
  localparam int AMP_W       = 17;
  localparam int MAXV_W      = 20;
  localparam int NUM_W       = TW + 1;
  localparam int DEN_W       = MAXV_W + 1;
  localparam int QUOT_W      = 17;
  localparam int OUT_W       = 16;

  localparam logic signed [DW-1:0] FX_ONE  = DW'(1 << FRAC_BITS);
  localparam logic signed [DW-1:0] FX_10   = DW'(10 << FRAC_BITS);
  localparam logic signed [DW-1:0] FX_15   = DW'(15 << FRAC_BITS);
  localparam logic signed [PW-1:0] FX_HALF = PW'(1 << (FRAC_BITS - 1));
  localparam logic [AMP_W-1:0]     AMP_ONE = AMP_W'(65536);

  // Input modes.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_2D   = 2'd1;
  localparam logic [1:0] MODE_3D   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_OCTAVES = 1'b0;
  localparam logic CFG_PERSIST = 1'b1;

  // Divider request and response words.
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [OUT_W-1:0]  quot;
  } div_rsp_t;

  // Dot product of one of sixteen gradient directions with a corner offset.
  function automatic logic signed [DW-1:0] grad_f(input logic [3:0] h,
                                                  input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] y,
                                                  input logic signed [DW-1:0] z);
    logic signed [DW-1:0] gu;
    logic signed [DW-1:0] gv;
    gu = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      gv = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = x;
    end else begin
      gv = z;
    end
    if (h[0]) begin
      gu = -gu;
    end
    if (h[1]) begin
      gv = -gv;
    end
    return gu + gv;
  endfunction

endpackage

// ===== rtl/gnos_ram.sv =====
// ----------------------------------------------------------------------------
// gnos_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gnos_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gnos_mul.sv =====
// ----------------------------------------------------------------------------
// gnos_mul: shared signed multiplier
// One signed multiply per cycle with a registered product; every fade,
// interpolation, weighting and amplitude step goes through this unit.
// ----------------------------------------------------------------------------
module gnos_mul (
  input  logic                          clk_i,
  input  logic signed [gnos_pkg::DW-1:0] a_i,
  input  logic signed [gnos_pkg::DW-1:0] b_i,
  output logic signed [gnos_pkg::PW-1:0] prod_o
);
  import gnos_pkg::*;

  logic signed [PW-1:0] prod_q;

  // Product register.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/gnos_div.sv =====
// ----------------------------------------------------------------------------
// gnos_div: iterative restoring divider
// Produces one quotient bit per cycle and saturates to the 16-bit range.
// ----------------------------------------------------------------------------
module gnos_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gnos_pkg::div_req_t  req_i,
  output gnos_pkg::div_rsp_t  rsp_o
);
  import gnos_pkg::*;

  localparam int HI_W  = NUM_W - QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy_q;
  logic              done_q;
  logic              sat_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DEN_W-1:0]  rem_q;
  logic [QUOT_W-1:0] low_q;
  logic [QUOT_W-1:0] quot_q;
  logic [HI_W-1:0]   hi;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;
  logic [DEN_W:0]    rem_sub;

  // Upper part of the dividend decides saturation up front.
  assign hi      = req_i.num[NUM_W-1:QUOT_W];
  assign rem_sh  = {rem_q, low_q[QUOT_W-1]};
  assign qbit    = rem_sh >= {1'b0, req_i.den};
  assign rem_sub = rem_sh - {1'b0, req_i.den};

  // Control and shift registers for the bit-per-cycle loop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (hi >= HI_W'(req_i.den)) begin
          sat_q  <= 1'b1;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          sat_q  <= 1'b0;
          rem_q  <= hi[DEN_W-1:0];
          low_q  <= req_i.num[QUOT_W-1:0];
          quot_q <= '0;
          cnt_q  <= CNT_W'(QUOT_W);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        low_q  <= {low_q[QUOT_W-2:0], 1'b0};
        quot_q <= {quot_q[QUOT_W-2:0], qbit};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = (sat_q || quot_q[QUOT_W-1]) ? {OUT_W{1'b1}} : quot_q[OUT_W-1:0];

endmodule

// ===== rtl/gradient_noise_octave_sum.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_octave_sum: multi-octave gradient noise evaluator
// The shared multiplier and the single table read port set the evaluation
// time. One evaluation at a time; a table load word leaves the input ready
// for the next word. Reset clears the control state and sets octave_count
// to 1 and persistence to 0.5; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_octave_sum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [16:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic signed [31:0]             coord_x_i,
  input  logic signed [31:0]             coord_y_i,
  input  logic signed [31:0]             coord_z_i,
  input  logic [7:0]                     entry_index_i,
  input  logic [7:0]                     entry_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gnos_pkg::OUT_W-1:0]     noise_value_o
);
  import gnos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_FADE_M, S_FADE_W, S_LERP_D, S_LERP_M, S_LERP_W,
    S_ACC_M, S_ACC_W, S_AMP_M, S_AMP_W, S_DIV, S_DIV_WAIT, S_OUT
  } state_e;

  localparam logic [3:0] HC_LAST_3D = 4'd13;
  localparam logic [3:0] HC_LAST_2D = 4'd9;

  state_e                state_q;
  logic [3:0]            octaves_q;
  logic [AMP_W-1:0]      persist_q;
  logic                  is3d_q;
  logic [CW-1:0]         cx_q, cy_q, cz_q;
  logic [3:0]            oc_eff_q, oct_q, oc_eff;
  logic [AMP_W-1:0]      pers_eff_q;
  logic [3:0]            hc_q, rd_tag_q, last_hc, tag_h1, tag_c;
  logic                  rd_vld_q;
  logic [TABLE_AW-1:0]   h0_q [2];
  logic [TABLE_AW-1:0]   h1_q [4];
  logic [TABLE_AW-1:0]   corner_q [8];
  logic [TABLE_AW-1:0]   rd_addr, rd_data, cell_x, cell_y, cell_z, off1;
  logic [1:0]            fs_q, ax_q;
  logic signed [DW-1:0]  poly_q, t2_q, t3_q, fu_q, fv_q, fw_q;
  logic [2:0]            lj_q;
  logic signed [DW-1:0]  la_q, ld_q, n1_q;
  logic signed [DW-1:0]  lr_q [6];
  logic [AMP_W-1:0]      amp_q;
  logic [MAXV_W-1:0]     maxv_q;
  logic signed [TW-1:0]  total_q;
  logic [OUT_W-1:0]      res_q, noise_q;
  logic                  out_valid_q;
  logic                  in_acc;
  logic signed [DW-1:0]  fx_s, fy_s, fz_s, fy_g, ft, six_t;
  logic signed [DW-1:0]  g_w [8];
  logic signed [DW-1:0]  lt, la, lb;
  logic                  l_last;
  logic signed [DW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod_w, rsum;
  logic signed [DW-1:0]  rnd;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  // Effective octave count, clamped to one through the maximum.
  always_comb begin
    if (octaves_q == 4'd0) begin
      oc_eff = 4'd1;
    end else if (octaves_q > 4'(MAX_OCTAVES)) begin
      oc_eff = 4'(MAX_OCTAVES);
    end else begin
      oc_eff = octaves_q;
    end
  end

  // Cell indexes and fractions of the scaled coordinate.
  assign cell_x  = cx_q[CW-1:FRAC_BITS];
  assign cell_y  = cy_q[CW-1:FRAC_BITS];
  assign cell_z  = cz_q[CW-1:FRAC_BITS];
  assign fx_s    = DW'(cx_q[FRAC_BITS-1:0]);
  assign fy_s    = DW'(cy_q[FRAC_BITS-1:0]);
  assign fz_s    = DW'(cz_q[FRAC_BITS-1:0]);
  assign fy_g    = is3d_q ? fy_s : '0;
  assign off1    = is3d_q ? cell_y : cell_z;
  assign last_hc = is3d_q ? HC_LAST_3D : HC_LAST_2D;
  assign tag_h1  = rd_tag_q - 4'd2;
  assign tag_c   = rd_tag_q - 4'd6;

  // Table read address for each step of the hash walk.
  always_comb begin
    unique case (hc_q)
      4'd0:    rd_addr = cell_x;
      4'd1:    rd_addr = cell_x + 1'b1;
      4'd2:    rd_addr = h0_q[0] + off1;
      4'd3:    rd_addr = h0_q[0] + off1 + 1'b1;
      4'd4:    rd_addr = h0_q[1] + off1;
      4'd5:    rd_addr = h0_q[1] + off1 + 1'b1;
      4'd6:    rd_addr = is3d_q ? h1_q[0] + cell_z : h1_q[0];
      4'd7:    rd_addr = is3d_q ? h1_q[0] + cell_z + 1'b1 : h1_q[1];
      4'd8:    rd_addr = is3d_q ? h1_q[1] + cell_z : h1_q[2];
      4'd9:    rd_addr = is3d_q ? h1_q[1] + cell_z + 1'b1 : h1_q[3];
      4'd10:   rd_addr = h1_q[2] + cell_z;
      4'd11:   rd_addr = h1_q[2] + cell_z + 1'b1;
      4'd12:   rd_addr = h1_q[3] + cell_z;
      4'd13:   rd_addr = h1_q[3] + cell_z + 1'b1;
      default: rd_addr = cell_x;
    endcase
  end

  gnos_ram #(
    .Width (TABLE_AW),
    .Depth (1 << TABLE_AW)
  ) u_perm (
    .clk_i   (clk_i),
    .we_i    (in_acc && mode_i == MODE_LOAD),
    .waddr_i (entry_index_i),
    .wdata_i (entry_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Corner gradients; in 2D the corner index holds the x and z bits only.
  for (genvar k = 0; k < 8; k++) begin : g_corner
    localparam logic [2:0] K = 3'(k);
    logic                 bx, by, bz;
    logic signed [DW-1:0] xa, ya, za;
    assign bx     = is3d_q ? K[2] : K[1];
    assign by     = K[1];
    assign bz     = K[0];
    assign xa     = bx ? fx_s - FX_ONE : fx_s;
    assign ya     = (is3d_q && by) ? fy_g - FX_ONE : fy_g;
    assign za     = bz ? fz_s - FX_ONE : fz_s;
    assign g_w[k] = grad_f(corner_q[k][3:0], xa, ya, za);
  end

  // Interpolation schedule: weight and the two end points of each step.
  always_comb begin
    lt     = fu_q;
    la     = '0;
    lb     = '0;
    l_last = 1'b0;
    if (is3d_q) begin
      unique case (lj_q)
        3'd0: begin la = g_w[0]; lb = g_w[4]; end
        3'd1: begin la = g_w[2]; lb = g_w[6]; end
        3'd2: begin lt = fv_q; la = lr_q[0]; lb = lr_q[1]; end
        3'd3: begin la = g_w[1]; lb = g_w[5]; end
        3'd4: begin la = g_w[3]; lb = g_w[7]; end
        3'd5: begin lt = fv_q; la = lr_q[3]; lb = lr_q[4]; end
        3'd6: begin lt = fw_q; la = lr_q[2]; lb = lr_q[5]; l_last = 1'b1; end
        default: ;
      endcase
    end else begin
      unique case (lj_q)
        3'd0: begin la = g_w[0]; lb = g_w[2]; end
        3'd1: begin la = g_w[1]; lb = g_w[3]; end
        3'd2: begin lt = fw_q; la = lr_q[0]; lb = lr_q[1]; l_last = 1'b1; end
        default: ;
      endcase
    end
  end

  // Fade input for the current axis and the 6t - 15 term.
  always_comb begin
    unique case (ax_q)
      2'd0:    ft = fx_s;
      2'd1:    ft = fy_s;
      default: ft = fz_s;
    endcase
  end
  assign six_t = (ft <<< 2) + (ft <<< 1) - FX_15;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_FADE_M: begin
        unique case (fs_q)
          2'd0: begin mul_a = ft;   mul_b = six_t;  end
          2'd1: begin mul_a = ft;   mul_b = ft;     end
          2'd2: begin mul_a = t2_q; mul_b = ft;     end
          2'd3: begin mul_a = t3_q; mul_b = poly_q; end
        endcase
      end
      S_LERP_M: begin mul_a = lt; mul_b = ld_q; end
      S_ACC_M:  begin mul_a = n1_q; mul_b = DW'(amp_q); end
      S_AMP_M:  begin mul_a = DW'(amp_q); mul_b = DW'(pers_eff_q); end
      default: ;
    endcase
  end

  gnos_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_w)
  );

  // Round to nearest of the registered product.
  assign rsum = prod_w + FX_HALF;
  assign rnd  = rsum[FRAC_BITS +: DW];

  // Final normalization: (total + sum of amplitudes) / (2 * sum of amplitudes).
  assign div_req.start = (state_q == S_DIV) && (total_q > 0);
  assign div_req.num   = {1'b0, total_q} + NUM_W'(maxv_q);
  assign div_req.den   = {maxv_q, 1'b0};

  gnos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer, configuration registers and output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      octaves_q   <= 4'd1;
      persist_q   <= AMP_W'(32768);
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      hc_q        <= '0;
      fs_q        <= '0;
      ax_q        <= '0;
      lj_q        <= '0;
      oct_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OCTAVES: octaves_q <= cfg_wdata_i[3:0];
          CFG_PERSIST: persist_q <= cfg_wdata_i;
        endcase
      end
      // The output state refills or holds the word register itself.
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (mode_i == MODE_2D || mode_i == MODE_3D)) begin
            is3d_q     <= (mode_i == MODE_3D);
            cx_q       <= coord_x_i[CW-1:0];
            cy_q       <= coord_y_i[CW-1:0];
            cz_q       <= coord_z_i[CW-1:0];
            oc_eff_q   <= oc_eff;
            pers_eff_q <= (persist_q > AMP_ONE) ? AMP_ONE : persist_q;
            oct_q      <= '0;
            amp_q      <= AMP_ONE;
            maxv_q     <= '0;
            total_q    <= '0;
            hc_q       <= '0;
            state_q    <= S_HASH;
          end
        end
        S_HASH: begin
          if (hc_q <= last_hc) begin
            rd_vld_q <= 1'b1;
            rd_tag_q <= hc_q;
            hc_q     <= hc_q + 1'b1;
          end
          if (rd_vld_q) begin
            if (rd_tag_q < 4'd2) begin
              h0_q[rd_tag_q[0]] <= rd_data;
            end else if (rd_tag_q < 4'd6) begin
              h1_q[tag_h1[1:0]] <= rd_data;
            end else begin
              corner_q[tag_c[2:0]] <= rd_data;
            end
            if (rd_tag_q == last_hc) begin
              fs_q    <= '0;
              ax_q    <= '0;
              state_q <= S_FADE_M;
            end
          end
        end
        S_FADE_M: state_q <= S_FADE_W;
        S_FADE_W: begin
          unique case (fs_q)
            2'd0: poly_q <= rnd + FX_10;
            2'd1: t2_q   <= rnd;
            2'd2: t3_q   <= rnd;
            2'd3: begin
              unique case (ax_q)
                2'd0:    fu_q <= rnd;
                2'd1:    fv_q <= rnd;
                default: fw_q <= rnd;
              endcase
            end
          endcase
          if (fs_q != 2'd3) begin
            fs_q    <= fs_q + 1'b1;
            state_q <= S_FADE_M;
          end else begin
            fs_q <= '0;
            if (ax_q == 2'd2) begin
              lj_q    <= '0;
              state_q <= S_LERP_D;
            end else begin
              ax_q    <= is3d_q ? ax_q + 1'b1 : 2'd2;
              state_q <= S_FADE_M;
            end
          end
        end
        S_LERP_D: begin
          la_q    <= la;
          ld_q    <= lb - la;
          state_q <= S_LERP_M;
        end
        S_LERP_M: state_q <= S_LERP_W;
        S_LERP_W: begin
          if (l_last) begin
            n1_q    <= la_q + rnd + FX_ONE;
            state_q <= S_ACC_M;
          end else begin
            lr_q[lj_q] <= la_q + rnd;
            lj_q       <= lj_q + 1'b1;
            state_q    <= S_LERP_D;
          end
        end
        S_ACC_M: state_q <= S_ACC_W;
        S_ACC_W: begin
          total_q <= total_q + signed'(prod_w[TW-1:0]);
          maxv_q  <= maxv_q + MAXV_W'(amp_q);
          state_q <= S_AMP_M;
        end
        S_AMP_M: state_q <= S_AMP_W;
        S_AMP_W: begin
          amp_q <= rnd[AMP_W-1:0];
          if (oct_q + 1'b1 == oc_eff_q) begin
            state_q <= S_DIV;
          end else begin
            oct_q   <= oct_q + 1'b1;
            cx_q    <= {cx_q[CW-2:0], 1'b0};
            cy_q    <= {cy_q[CW-2:0], 1'b0};
            cz_q    <= {cz_q[CW-2:0], 1'b0};
            hc_q    <= '0;
            state_q <= S_HASH;
          end
        end
        S_DIV: begin
          if (total_q > 0) begin
            state_q <= S_DIV_WAIT;
          end else begin
            res_q   <= '0;
            state_q <= S_OUT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            res_q   <= div_rsp.quot;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            noise_q     <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gnos_checker.sv =====
// ----------------------------------------------------------------------------
// gnos_checker: port-level checks for the gradient noise octave sum
// Watches the handshakes and the busy behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module gnos_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] noise_value_o
);
  import gnos_pkg::*;

  // A waiting output word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("output word changed or dropped while stalled");

  // An evaluation keeps the input side closed on the next cycle.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_2D || mode_i == MODE_3D)
    |=> !in_ready_o)
    else $error("input accepted again right after an evaluation started");

  // A table load leaves the block ready for the next word.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_LOAD |=> in_ready_o)
    else $error("block went busy after a table load");

  // A new result appears exactly when the sequencer returns to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result presented while the sequencer is still busy");

endmodule

bind gradient_noise_octave_sum gnos_checker u_gnos_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .mode_i        (mode_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .noise_value_o (noise_value_o)
);

// ===== verif/tb_gradient_noise_octave_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_octave_sum: self-checking bench for the octave noise sum
// Loads a shuffled permutation table, then sends directed and random 2D, 3D,
// load and unused-mode words under several octave and persistence settings.
// A local fixed-point predictor computes each expected noise word, which the
// output monitor compares in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_gradient_noise_octave_sum;
  import gnos_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 800;
  localparam int STALL_LIMIT  = 20000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         idx;
    logic [7:0]         val;
  } noise_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [16:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_y_i;
  logic signed [31:0] coord_z_i;
  logic [7:0]         entry_index_i;
  logic [7:0]         entry_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [OUT_W-1:0]   noise_value_o;

  gradient_noise_octave_sum dut (.*);

  // Shadow state of the block.
  logic [7:0]  perm_shadow [256];
  logic [3:0]  octaves_shadow;
  logic [16:0] persist_shadow;

  noise_req_t     pending_q [$];
  logic [15:0]    noise_exp_q [$];
  bit             no_idle;
  int             mismatches;
  int             checked;
  int             sent_2d, sent_3d, sent_load;
  int             idle_cycles;
  int             in_gap, out_gap;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- Predictor ----------------
  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint fade_curve(longint t);
    longint t3;
    longint poly;
    t3   = fx_mul(fx_mul(t, t), t);
    poly = fx_mul(t, 6 * t - 15 * 65536) + 10 * 65536;
    return fx_mul(t3, poly);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + fx_mul(t, b - a);
  endfunction

  function automatic longint grad_dot(int unsigned hash, longint x, longint y, longint z);
    int unsigned h;
    longint gu;
    longint gv;
    h  = hash & 15;
    gu = (h < 8) ? x : y;
    gv = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h & 1) gu = -gu;
    if (h & 2) gv = -gv;
    return gu + gv;
  endfunction

  function automatic int unsigned perm_at(int unsigned i);
    return perm_shadow[i & 255];
  endfunction

  function automatic longint noise_2d(longint cx, longint cz);
    int unsigned cxi, czi, ha, hb;
    longint fx, fz, u, w, r1, r2;
    cxi = int'((cx >>> 16) & 255);
    czi = int'((cz >>> 16) & 255);
    fx  = cx & 65535;
    fz  = cz & 65535;
    u   = fade_curve(fx);
    w   = fade_curve(fz);
    ha  = perm_at(cxi) + czi;
    hb  = perm_at(cxi + 1) + czi;
    r1  = blend(u, grad_dot(perm_at(perm_at(ha)), fx, 0, fz),
                grad_dot(perm_at(perm_at(hb)), fx - 65536, 0, fz));
    r2  = blend(u, grad_dot(perm_at(perm_at(ha + 1)), fx, 0, fz - 65536),
                grad_dot(perm_at(perm_at(hb + 1)), fx - 65536, 0, fz - 65536));
    return blend(w, r1, r2);
  endfunction

  function automatic longint noise_3d(longint cx, longint cy, longint cz);
    int unsigned xi, yi, zi, ha, hb, aa, ab, ba, bb;
    longint fx, fy, fz, u, v, w, r1, r2;
    xi = int'((cx >>> 16) & 255);
    yi = int'((cy >>> 16) & 255);
    zi = int'((cz >>> 16) & 255);
    fx = cx & 65535;
    fy = cy & 65535;
    fz = cz & 65535;
    u  = fade_curve(fx);
    v  = fade_curve(fy);
    w  = fade_curve(fz);
    ha = perm_at(xi) + yi;
    hb = perm_at(xi + 1) + yi;
    aa = perm_at(ha) + zi;
    ab = perm_at(ha + 1) + zi;
    ba = perm_at(hb) + zi;
    bb = perm_at(hb + 1) + zi;
    r1 = blend(v,
           blend(u, grad_dot(perm_at(aa), fx, fy, fz),
                    grad_dot(perm_at(ba), fx - 65536, fy, fz)),
           blend(u, grad_dot(perm_at(ab), fx, fy - 65536, fz),
                    grad_dot(perm_at(bb), fx - 65536, fy - 65536, fz)));
    r2 = blend(v,
           blend(u, grad_dot(perm_at(aa + 1), fx, fy, fz - 65536),
                    grad_dot(perm_at(ba + 1), fx - 65536, fy, fz - 65536)),
           blend(u, grad_dot(perm_at(ab + 1), fx, fy - 65536, fz - 65536),
                    grad_dot(perm_at(bb + 1), fx - 65536, fy - 65536, fz - 65536)));
    return blend(w, r1, r2);
  endfunction

  // Weighted octave sum, normalized and saturated to 16 bits.
  function automatic logic [15:0] octave_noise(noise_req_t r);
    int unsigned      oc;
    longint unsigned  pers, amp, amp_sum, num, den, q;
    longint           total, n, m;
    oc      = octaves_shadow;
    if (oc == 0) oc = 1;
    if (oc > MAX_OCTAVES) oc = MAX_OCTAVES;
    pers    = (persist_shadow > 17'd65536) ? 65536 : persist_shadow;
    amp     = 65536;
    amp_sum = 0;
    total   = 0;
    for (int i = 0; i < oc; i++) begin
      m = longint'(1) << i;
      if (r.mode == MODE_2D) n = noise_2d(longint'(r.x) * m, longint'(r.z) * m);
      else n = noise_3d(longint'(r.x) * m, longint'(r.y) * m, longint'(r.z) * m);
      total   += (n + 65536) * longint'(amp);
      amp_sum += amp;
      amp      = (amp * pers + 32768) >> 16;
    end
    if (total <= 0) return 16'd0;
    num = longint'(total) << 16;
    den = amp_sum << 17;
    q   = (num + (den >> 1)) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Apply one accepted word to the shadow state and queue any result.
  function automatic void absorb_word(noise_req_t r);
    case (r.mode)
      MODE_LOAD: begin
        perm_shadow[r.idx] = r.val;
        sent_load++;
      end
      MODE_2D: begin
        noise_exp_q.push_back(octave_noise(r));
        sent_2d++;
      end
      MODE_3D: begin
        noise_exp_q.push_back(octave_noise(r));
        sent_3d++;
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(80, 20);
  endfunction

  // ---------------- Input driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    noise_req_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      mode_i        <= MODE_UNUSED;
      coord_x_i     <= '0;
      coord_y_i     <= '0;
      coord_z_i     <= '0;
      entry_index_i <= '0;
      entry_value_i <= '0;
      in_gap        <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        absorb_word('{mode_i, coord_x_i, coord_y_i, coord_z_i, entry_index_i,
                      entry_value_i});
      end
      if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt            = pending_q.pop_front();
        mode_i        <= nxt.mode;
        coord_x_i     <= nxt.x;
        coord_y_i     <= nxt.y;
        coord_z_i     <= nxt.z;
        entry_index_i <= nxt.idx;
        entry_value_i <= nxt.val;
        in_valid_i    <= 1'b1;
        in_gap        <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- Output monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (noise_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected noise word %0d", noise_value_o);
        end else begin
          want = noise_exp_q.pop_front();
          checked++;
          if (noise_value_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: noise_value expected %0d got %0d", want, noise_value_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(3) == 0) out_gap <= pick_gap();
      end
    end
  end

  // ---------------- Watchdog ----------------
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (pending_q.size() == 0 && !in_valid_i && noise_exp_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- Stimulus ----------------
  task automatic write_reg(logic idx, logic [16:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_OCTAVES) octaves_shadow = data[3:0];
    else persist_shadow = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_q.size() == 0 && !in_valid_i && noise_exp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic noise_req_t eval_word(logic [1:0] mode, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z);
    return '{mode, x, y, z, 8'($urandom), 8'($urandom)};
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(3))
      0:       return c;
      1:       return {{12{c[31]}}, c[19:0]};
      2:       return {{16{c[31]}}, c[15:0]} | 32'h0000_FFFF;
      default: return {{8{c[31]}}, c[23:0]};
    endcase
  endfunction

  function automatic noise_req_t rand_word();
    int p;
    p = $urandom_range(99);
    if (p < 5) return '{MODE_LOAD, $urandom, $urandom, $urandom, 8'($urandom),
                        8'($urandom)};
    if (p < 9) return eval_word(MODE_UNUSED, $urandom, $urandom, $urandom);
    return eval_word((p < 55) ? MODE_2D : MODE_3D, rand_coord(), rand_coord(),
                     rand_coord());
  endfunction

  initial begin
    int          perm [256];
    int          j, tmp;
    logic [31:0] edge_vals [6];
    int          oct_set  [8];
    int          pers_set [8];

    edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'h00FF_FFFF};
    oct_set   = '{8, 1, 0, 15, 4, 2, 8, 3};
    pers_set  = '{65536, 0, 12345, 131071, 32768, 65535, 0, 50000};
    mismatches = 0;
    checked    = 0;
    sent_2d = 0; sent_3d = 0; sent_load = 0;
    idle_cycles    = 0;
    no_idle        = 0;
    octaves_shadow = 4'd1;
    persist_shadow = 17'd32768;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_OCTAVES;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole table with a shuffled permutation before any evaluation.
    for (int i = 0; i < 256; i++) perm[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      pending_q.push_back('{MODE_LOAD, 32'h0, 32'h0, 32'h0, 8'(i), 8'(perm[i])});

    // Directed words at reset settings: coordinate extremes in both modes,
    // the unused mode, and a load that rewrites an entry with the same value.
    for (int i = 0; i < 6; i++) begin
      pending_q.push_back(eval_word(MODE_2D, edge_vals[i], edge_vals[5 - i], edge_vals[i]));
      pending_q.push_back(eval_word(MODE_3D, edge_vals[i], edge_vals[i], edge_vals[5 - i]));
    end
    pending_q.push_back(eval_word(MODE_UNUSED, 32'hFFFF_FFFF, 32'h0, 32'h0));
    pending_q.push_back('{MODE_LOAD, 32'h0, 32'h0, 32'h0, 8'hFF, 8'(perm[255])});
    wait_drained();

    // Random phases, each under its own octave and persistence setting.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_OCTAVES, {13'($urandom_range(8191)), 4'(oct_set[ph])});
      write_reg(CFG_PERSIST, 17'(pers_set[ph]));
      no_idle = (ph == 4);
      for (int i = 0; i < 160; i++) pending_q.push_back(rand_word());
      wait_drained();
    end

    $display("Checked %0d noise words from %0d 2D and %0d 3D requests, %0d table loads,",
             checked, sent_2d, sent_3d, sent_load);
    $display("over octave counts 0 to 15 and persistence 0 to above one.");
    if (mismatches == 0 && noise_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
